### rtl/rlfc_pkg.sv
// Shared types, constants and codes of the receiver-loss failsafe controller.
package rlfc_pkg;

    // Time arithmetic width; every timestamp wraps modulo 2^TIME_BITS (16 to 64).
    localparam int TIME_BITS = 32;
    typedef logic [TIME_BITS-1:0] t_time;

    localparam int NOW_W      = 32;
    localparam int SUS_W      = 32;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int HOLD_W     = 15;
    localparam int EVT_W      = 16;
    localparam int THR_W      = 11;

    localparam int TENTH_MS        = 100;
    localparam int RX_FAIL_BASE_MS = 200;
    localparam int RX_RECOVER_MS   = 200;
    localparam int HOLD_1S         = 1000;
    localparam int HOLD_3S         = 3000;
    localparam int HOLD_30S        = 30000;

    // Phase passes allowed in one update.
    localparam int MAX_PASSES = 8;
    localparam int PASS_W     = $clog2(MAX_PASSES);

    // x / 1000 for any 32-bit x: (x * DIV_RECIP) >> DIV_SHIFT; quotient up to 4294967.
    localparam logic [SUS_W-1:0] DIV_RECIP = 32'd274877907;
    localparam int DIV_SHIFT = 38;
    localparam int QUOT_W    = 23;

    typedef enum logic [2:0] {
        FN_UPDATE  = 3'd0,
        FN_GOOD    = 3'd1,
        FN_BAD     = 3'd2,
        FN_SUSPEND = 3'd3,
        FN_RESUME  = 3'd4
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAIL_DELAY = 3'd0,
        CFG_LAND_TIME  = 3'd1,
        CFG_LAND_THR   = 3'd2,
        CFG_THR_LOW    = 3'd3,
        CFG_KILL_MODE  = 3'd4,
        CFG_PROCEDURE  = 3'd5,
        CFG_MONITOR    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_LOSS      = 3'd1,
        PH_LANDING   = 3'd2,
        PH_LANDED    = 3'd3,
        PH_MONITOR   = 3'd4,
        PH_RECOVERED = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        LK_NONE  = 2'd0,
        LK_SET   = 2'd1,
        LK_CLEAR = 2'd2
    } t_lock;

    typedef struct packed {
        logic [2:0]       func;
        logic [NOW_W-1:0] now_ms;
        logic [SUS_W-1:0] suspend_us;
        logic             armed;
        logic             throttle_low;
        logic             switch_on;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       phase_now;
        logic             is_active;
        logic             link_is_up;
        logic             apply_override;
        logic [THR_W-1:0] throttle_out;
        logic             disarm_now;
        logic [1:0]       arming_lock;
        logic [EVT_W-1:0] event_total;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SUS,
        ST_PASS,
        ST_DONE
    } t_ctl_state;

    typedef struct packed {
        logic capture;
        logic decode;
        logic sus_add;
        logic pass_step;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_suspend;
        logic is_update_run;
        logic again;
    } t_dp_status;

endpackage

### rtl/rlfc_in_if.sv
// Input channel: valid/ready handshake carrying one event transaction.
interface rlfc_in_if;
    import rlfc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/rlfc_out_if.sv
// Output channel: valid/ready handshake carrying one result transaction.
interface rlfc_out_if;
    import rlfc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/rlfc_datapath.sv
// Datapath: configuration, link tracking, phase pass logic and result register.
module rlfc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rlfc_pkg::t_ctl_cmd                i_cmd,
    output rlfc_pkg::t_dp_status              o_status,
    input  rlfc_pkg::t_in_item                i_item,
    input  logic                              i_cfg_we,
    input  logic [rlfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rlfc_pkg::CFG_W-1:0]        i_cfg_wdata,
    output rlfc_pkg::t_out_item               o_item
);
    import rlfc_pkg::*;

    // Configuration registers
    logic [7:0]       r_cfg_fail;
    logic [7:0]       r_cfg_land_time;
    logic [THR_W-1:0] r_cfg_land_thr;
    logic [8:0]       r_cfg_thr_low;
    logic             r_cfg_kill;
    logic             r_cfg_proc;
    logic             r_cfg_monitor;

    // Captured transaction
    logic [2:0]       r_func;
    t_time            r_now;
    logic [SUS_W-1:0] r_sus;
    logic             r_armed;
    logic             r_thr_low;
    logic             r_sw_on;

    // Failsafe state
    t_phase           r_phase;
    logic             r_active;
    logic             r_link;
    t_time            r_good;
    t_time            r_bad;
    t_time            r_thr_dl;
    t_time            r_land_dl;
    t_time            r_rearm_dl;
    logic [HOLD_W-1:0] r_hold;
    logic [EVT_W-1:0] r_evt;

    // Per-update actions
    logic             r_ovr;
    logic             r_disarm;
    t_lock            r_lock;

    logic [QUOT_W-1:0] r_quot;
    t_out_item         r_out;

    // Next values of one phase pass
    t_phase            n_phase;
    logic              n_active;
    t_time             n_thr_dl;
    t_time             n_land_dl;
    t_time             n_rearm_dl;
    logic [HOLD_W-1:0] n_hold;
    logic [EVT_W-1:0]  n_evt;
    logic              n_ovr;
    logic              n_disarm;
    t_lock             n_lock;
    logic              pass_again;

    logic [2*SUS_W-1:0] sus_prod;
    t_time low_period;
    t_time land_period;
    t_time fail_window;
    t_time thr_dl_new;
    t_time thr_dl_eff;
    t_time good_age;
    t_time bad_age;
    t_time rearm_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fail      <= 8'd10;
            r_cfg_land_time <= 8'd200;
            r_cfg_land_thr  <= THR_W'(1000);
            r_cfg_thr_low   <= 9'd100;
            r_cfg_kill      <= 1'b0;
            r_cfg_proc      <= 1'b0;
            r_cfg_monitor   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAIL_DELAY: r_cfg_fail      <= i_cfg_wdata[7:0];
                CFG_LAND_TIME:  r_cfg_land_time <= i_cfg_wdata[7:0];
                CFG_LAND_THR:   r_cfg_land_thr  <= i_cfg_wdata[THR_W-1:0];
                CFG_THR_LOW:    r_cfg_thr_low   <= i_cfg_wdata[8:0];
                CFG_KILL_MODE:  r_cfg_kill      <= i_cfg_wdata[0];
                CFG_PROCEDURE:  r_cfg_proc      <= i_cfg_wdata[0];
                CFG_MONITOR:    r_cfg_monitor   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        low_period  = t_time'(r_cfg_thr_low * TENTH_MS);
        land_period = t_time'(r_cfg_land_time * TENTH_MS);
        fail_window = t_time'(RX_FAIL_BASE_MS + r_cfg_fail * TENTH_MS);
        good_age    = r_now - r_bad;
        bad_age     = r_now - r_good;
        thr_dl_new  = r_now + low_period;
        rearm_new   = r_now + t_time'(r_hold);
        sus_prod    = {{SUS_W{1'b0}}, r_sus} * {{SUS_W{1'b0}}, DIV_RECIP};
    end

    // One pass of the phase machine; link state is fixed for the whole update.
    always_comb begin
        n_phase    = r_phase;
        n_active   = r_active;
        n_thr_dl   = r_thr_dl;
        n_land_dl  = r_land_dl;
        n_rearm_dl = r_rearm_dl;
        n_hold     = r_hold;
        n_evt      = r_evt;
        n_ovr      = r_ovr;
        n_disarm   = r_disarm;
        n_lock     = r_lock;
        pass_again = 1'b0;
        thr_dl_eff = r_thr_low ? r_thr_dl : thr_dl_new;
        unique case (r_phase)
            PH_IDLE: begin
                if (r_armed) begin
                    n_thr_dl = thr_dl_eff;
                    if (r_sw_on && r_cfg_kill) begin
                        n_active   = 1'b1;
                        n_land_dl  = r_now + land_period;
                        n_evt      = (r_evt != '1) ? r_evt + 1'b1 : r_evt;
                        n_phase    = PH_LANDED;
                        n_hold     = HOLD_W'(HOLD_1S);
                        pass_again = 1'b1;
                    end else if (!r_link) begin
                        if (r_now > thr_dl_eff) begin
                            n_active  = 1'b1;
                            n_land_dl = r_now + land_period;
                            n_evt     = (r_evt != '1) ? r_evt + 1'b1 : r_evt;
                            n_phase   = PH_LANDED;
                            n_hold    = HOLD_W'(HOLD_3S);
                        end else begin
                            n_phase = PH_LOSS;
                        end
                        pass_again = 1'b1;
                    end
                end else begin
                    n_thr_dl = '0;
                end
            end
            PH_LOSS: begin
                if (r_link) begin
                    n_phase = PH_RECOVERED;
                end else begin
                    n_active  = 1'b1;
                    n_land_dl = r_now + land_period;
                    n_evt     = (r_evt != '1) ? r_evt + 1'b1 : r_evt;
                    n_phase   = PH_LANDING;
                    if (r_cfg_proc) begin
                        n_phase = PH_LANDED;
                        n_hold  = HOLD_W'(HOLD_3S);
                    end
                end
                pass_again = 1'b1;
            end
            PH_LANDING: begin
                if (r_link) begin
                    n_phase    = PH_RECOVERED;
                    pass_again = 1'b1;
                end
                if (r_armed) begin
                    n_ovr = 1'b1;
                end
                // Landing timeout or disarmed wins over recovery
                if ((r_now > r_land_dl) || !r_armed) begin
                    n_hold     = HOLD_W'(HOLD_30S);
                    n_phase    = PH_LANDED;
                    pass_again = 1'b1;
                end
            end
            PH_LANDED: begin
                n_lock     = LK_SET;
                n_disarm   = 1'b1;
                n_rearm_dl = rearm_new;
                n_phase    = PH_MONITOR;
                pass_again = 1'b1;
            end
            PH_MONITOR: begin
                if (r_link) begin
                    if (r_now > r_rearm_dl) begin
                        n_lock     = LK_CLEAR;
                        n_phase    = PH_RECOVERED;
                        pass_again = 1'b1;
                    end
                end else begin
                    n_rearm_dl = rearm_new;
                end
            end
            PH_RECOVERED: begin
                n_thr_dl   = thr_dl_new;
                n_phase    = PH_IDLE;
                n_active   = 1'b0;
                pass_again = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_active   <= 1'b0;
            r_link     <= 1'b0;
            r_good     <= '0;
            r_bad      <= '0;
            r_thr_dl   <= '0;
            r_land_dl  <= '0;
            r_rearm_dl <= '0;
            r_hold     <= '0;
            r_evt      <= '0;
            r_ovr      <= 1'b0;
            r_disarm   <= 1'b0;
            r_lock     <= LK_NONE;
        end else if (i_cmd.capture) begin
            r_ovr    <= 1'b0;
            r_disarm <= 1'b0;
            r_lock   <= LK_NONE;
        end else if (i_cmd.decode) begin
            unique case (r_func)
                FN_GOOD: begin
                    r_good <= r_now;
                    if (good_age > t_time'(RX_RECOVER_MS)) begin
                        r_link <= 1'b1;
                    end
                end
                FN_BAD: begin
                    r_bad <= r_now;
                    if (bad_age > fail_window) begin
                        r_link <= 1'b0;
                    end
                end
                FN_RESUME: begin
                    r_good <= r_now;
                    r_link <= 1'b1;
                end
                default: ;
            endcase
        end else if (i_cmd.sus_add) begin
            r_good <= r_good + t_time'(r_quot);
        end else if (i_cmd.pass_step) begin
            r_phase    <= n_phase;
            r_active   <= n_active;
            r_thr_dl   <= n_thr_dl;
            r_land_dl  <= n_land_dl;
            r_rearm_dl <= n_rearm_dl;
            r_hold     <= n_hold;
            r_evt      <= n_evt;
            r_ovr      <= n_ovr;
            r_disarm   <= n_disarm;
            r_lock     <= n_lock;
        end
    end

    // Transaction capture, quotient register and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_item.func;
            r_now     <= t_time'(i_item.now_ms);
            r_sus     <= i_item.suspend_us;
            r_armed   <= i_item.armed;
            r_thr_low <= i_item.throttle_low;
            r_sw_on   <= i_item.switch_on;
        end
        if (i_cmd.decode) begin
            r_quot <= sus_prod[DIV_SHIFT +: QUOT_W];
        end
        if (i_cmd.out_load) begin
            r_out.phase_now      <= r_phase;
            r_out.is_active      <= r_active;
            r_out.link_is_up     <= r_link;
            r_out.apply_override <= r_ovr;
            r_out.throttle_out   <= r_cfg_land_thr;
            r_out.disarm_now     <= r_disarm;
            r_out.arming_lock    <= r_lock;
            r_out.event_total    <= r_evt;
        end
    end

    assign o_status.is_suspend    = (r_func == FN_SUSPEND);
    assign o_status.is_update_run = (r_func == FN_UPDATE) && r_cfg_monitor;
    assign o_status.again         = pass_again;
    assign o_item                 = r_out;

endmodule

### rtl/rlfc_ctrl.sv
// Controller: sequences capture, event decode, suspend add, phase passes and result hand-off.
module rlfc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  rlfc_pkg::t_dp_status  i_status,
    output rlfc_pkg::t_ctl_cmd    o_cmd
);
    import rlfc_pkg::*;

    t_ctl_state        r_state;
    t_ctl_state        n_state;
    logic [PASS_W-1:0] r_pass_cnt;
    logic              r_out_valid;
    logic              last_pass;
    logic              out_free;

    assign last_pass = (r_pass_cnt == PASS_W'(MAX_PASSES - 1));
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (i_status.is_suspend) begin
                    n_state = ST_SUS;
                end else if (i_status.is_update_run) begin
                    n_state = ST_PASS;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SUS: n_state = ST_DONE;
            ST_PASS: begin
                if (!i_status.again || last_pass) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_DECODE: o_cmd.decode    = 1'b1;
            ST_SUS:    o_cmd.sus_add   = 1'b1;
            ST_PASS:   o_cmd.pass_step = 1'b1;
            ST_DONE:   o_cmd.out_load  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // restart the pass count for every transaction
            if (r_state == ST_DECODE) begin
                r_pass_cnt <= '0;
            end else if (r_state == ST_PASS) begin
                r_pass_cnt <= r_pass_cnt + 1'b1;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_pass_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) && !i_status.again |=> (r_state == ST_DONE))
        else $error("phase chain kept running after a final pass");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded over an unread result");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && i_in_valid |=> (r_state == ST_DECODE))
        else $error("accepted transaction not decoded");

    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) && last_pass |=> (r_state == ST_DONE))
        else $error("phase chain exceeded its pass limit");

endmodule

### rtl/rx_loss_failsafe_controller_unit.sv
// Top level of the receiver-loss failsafe controller.
//
//  Port            Dir   Kind          Contents
//  i_in            in    valid/ready   func, now_ms, suspend_us, armed, throttle_low, switch_on
//  o_out           out   valid/ready   phase, active, link, override, throttle, disarm, lock, count
//  i_cfg_*         in    write only    i_cfg_we, i_cfg_idx, i_cfg_wdata
//
// One transaction at a time: frame, bad frame, resume and unused events go from acceptance
// through decode to the result step, suspend also runs an add step (registered divide-by-1000
// multiply, then add), and an update runs its phase passes between decode and the result step,
// none with monitoring off and at most 8 otherwise.
// A finished result sits in the output register; the next transaction is accepted meanwhile
// and waits in its last step until that register is free.
// Synchronous active-low reset restores configuration and failsafe state to defaults.
module rx_loss_failsafe_controller_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rlfc_in_if.sink                         i_in,
    rlfc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [rlfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlfc_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import rlfc_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    rlfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (ctl_cmd)
    );

    rlfc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_status    (dp_status),
        .i_item      (i_in.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_item      (o_out.data)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for the receiver-loss failsafe controller: directed, mixed and wrap-around runs.
module tb;
    import rlfc_pkg::*;

    localparam int CYCLE_LIMIT     = 2_500_000;
    localparam int RESET_CYCLES    = 7;
    localparam int DRAIN_CYCLES    = 24;
    localparam int MAX_REPORTS     = 40;
    localparam int NUM_SEGMENTS    = 8;
    localparam int SEG_ITEMS       = 240;
    localparam int WRAP_UPDATES    = 24;
    localparam int NUM_REGS        = int'(CFG_MONITOR) + 1;

    localparam logic [2:0]       FN_UNUSED_LO = FN_RESUME + 3'd1;
    localparam logic [2:0]       FN_UNUSED_HI = '1;
    localparam logic [SUS_W-1:0] US_PER_MS    = 1000;
    localparam t_time            TIME_MAX     = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_FAIL_DELAY;
    logic [CFG_W-1:0] cfg_wdata = '0;

    rlfc_in_if  ev_ch ();
    rlfc_out_if st_ch ();

    rx_loss_failsafe_controller_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (ev_ch),
        .o_out       (st_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    int unsigned cycle_count = 0;
    int          mismatch_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          in_idle_pct = 0;
    int          out_stall_pct = 0;

    t_out_item predicted_status[$];

    // Shadow configuration, reset values
    logic [7:0]  cf_fail_delay = 8'd10;
    logic [7:0]  cf_land_time  = 8'd200;
    logic [10:0] cf_land_thr   = 11'd1000;
    logic [8:0]  cf_thr_low    = 9'd100;
    logic        cf_kill       = 1'b0;
    logic        cf_drop       = 1'b0;
    logic        cf_monitor    = 1'b0;

    // Shadow failsafe state
    t_phase              fs_phase    = PH_IDLE;
    logic                fs_active   = 1'b0;
    logic                fs_link_up  = 1'b0;
    t_time               fs_good_ms  = '0;
    t_time               fs_bad_ms   = '0;
    t_time               fs_thr_dl   = '0;
    t_time               fs_land_dl  = '0;
    t_time               fs_rearm_dl = '0;
    logic [HOLD_W-1:0]   fs_hold     = '0;
    logic [EVT_W-1:0]    fs_events   = '0;

    function automatic void start_failsafe(input t_time now);
        fs_active  = 1'b1;
        fs_phase   = PH_LANDING;
        fs_land_dl = now + t_time'(cf_land_time) * t_time'(TENTH_MS);
        if (fs_events != '1)
            fs_events = fs_events + 1'b1;
    endfunction

    function automatic t_out_item failsafe_step(input t_in_item ev);
        t_out_item res;
        t_time     now;
        t_time     span;
        t_time     low_per;
        t_time     fail_win;
        logic      rx_ok;
        logic      again;
        logic      ovr;
        logic      dis;
        t_lock     lk;
        now      = ev.now_ms;
        low_per  = t_time'(cf_thr_low) * t_time'(TENTH_MS);
        fail_win = t_time'(RX_FAIL_BASE_MS) + t_time'(cf_fail_delay) * t_time'(TENTH_MS);
        ovr = 1'b0;
        dis = 1'b0;
        lk  = LK_NONE;
        case (ev.func)
            FN_GOOD: begin
                fs_good_ms = now;
                span = fs_good_ms - fs_bad_ms;
                if (span > t_time'(RX_RECOVER_MS))
                    fs_link_up = 1'b1;
            end
            FN_BAD: begin
                fs_bad_ms = now;
                span = fs_bad_ms - fs_good_ms;
                if (span > fail_win)
                    fs_link_up = 1'b0;
            end
            FN_SUSPEND: begin
                fs_good_ms = fs_good_ms + t_time'(ev.suspend_us / US_PER_MS);
            end
            FN_RESUME: begin
                fs_good_ms = now;
                fs_link_up = 1'b1;
            end
            FN_UPDATE: begin
                if (cf_monitor) begin
                    rx_ok = fs_link_up;
                    again = 1'b1;
                    for (int pass = 0; pass < MAX_PASSES && again; pass++) begin
                        again = 1'b0;
                        case (fs_phase)
                            PH_IDLE: begin
                                if (ev.armed) begin
                                    if (!ev.throttle_low)
                                        fs_thr_dl = now + low_per;
                                    if (ev.switch_on && cf_kill) begin
                                        start_failsafe(now);
                                        fs_phase = PH_LANDED;
                                        fs_hold  = HOLD_W'(HOLD_1S);
                                        again    = 1'b1;
                                    end else if (!rx_ok) begin
                                        // long low throttle means the craft is on the ground
                                        if (now > fs_thr_dl) begin
                                            start_failsafe(now);
                                            fs_phase = PH_LANDED;
                                            fs_hold  = HOLD_W'(HOLD_3S);
                                        end else begin
                                            fs_phase = PH_LOSS;
                                        end
                                        again = 1'b1;
                                    end
                                end else begin
                                    fs_thr_dl = '0;
                                end
                            end
                            PH_LOSS: begin
                                if (rx_ok) begin
                                    fs_phase = PH_RECOVERED;
                                end else begin
                                    start_failsafe(now);
                                    if (cf_drop) begin
                                        fs_phase = PH_LANDED;
                                        fs_hold  = HOLD_W'(HOLD_3S);
                                    end
                                end
                                again = 1'b1;
                            end
                            PH_LANDING: begin
                                if (rx_ok) begin
                                    fs_phase = PH_RECOVERED;
                                    again    = 1'b1;
                                end
                                if (ev.armed)
                                    ovr = 1'b1;
                                // timeout or disarm overrides a recovery seen in this pass
                                if (now > fs_land_dl || !ev.armed) begin
                                    fs_hold  = HOLD_W'(HOLD_30S);
                                    fs_phase = PH_LANDED;
                                    again    = 1'b1;
                                end
                            end
                            PH_LANDED: begin
                                lk          = LK_SET;
                                dis         = 1'b1;
                                fs_rearm_dl = now + t_time'(fs_hold);
                                fs_phase    = PH_MONITOR;
                                again       = 1'b1;
                            end
                            PH_MONITOR: begin
                                if (rx_ok) begin
                                    if (now > fs_rearm_dl) begin
                                        lk       = LK_CLEAR;
                                        fs_phase = PH_RECOVERED;
                                        again    = 1'b1;
                                    end
                                end else begin
                                    fs_rearm_dl = now + t_time'(fs_hold);
                                end
                            end
                            PH_RECOVERED: begin
                                fs_thr_dl = now + low_per;
                                fs_phase  = PH_IDLE;
                                fs_active = 1'b0;
                                again     = 1'b1;
                            end
                            default: fs_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        res.phase_now      = fs_phase;
        res.is_active      = fs_active;
        res.link_is_up     = fs_link_up;
        res.apply_override = ovr;
        res.throttle_out   = cf_land_thr;
        res.disarm_now     = dis;
        res.arming_lock    = lk;
        res.event_total    = fs_events;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR cycle %0d: %s got 0x%0h, want 0x%0h", cycle_count, what, got, want);
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk) begin
        if (!rst_n)
            st_ch.ready <= 1'b0;
        else
            st_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    always @(posedge clk) begin : check_status
        t_out_item got;
        t_out_item want;
        if (rst_n && st_ch.valid && st_ch.ready) begin
            got = st_ch.data;
            if (predicted_status.size() == 0) begin
                report_mismatch("result with nothing pending", got[31:0], '0);
            end else begin
                want = predicted_status.pop_front();
                checked_count++;
                if (got.phase_now !== want.phase_now)
                    report_mismatch("phase_now", 32'(got.phase_now), 32'(want.phase_now));
                if (got.is_active !== want.is_active)
                    report_mismatch("is_active", 32'(got.is_active), 32'(want.is_active));
                if (got.link_is_up !== want.link_is_up)
                    report_mismatch("link_is_up", 32'(got.link_is_up), 32'(want.link_is_up));
                if (got.apply_override !== want.apply_override)
                    report_mismatch("apply_override", 32'(got.apply_override),
                                    32'(want.apply_override));
                if (got.throttle_out !== want.throttle_out)
                    report_mismatch("throttle_out", 32'(got.throttle_out),
                                    32'(want.throttle_out));
                if (got.disarm_now !== want.disarm_now)
                    report_mismatch("disarm_now", 32'(got.disarm_now), 32'(want.disarm_now));
                if (got.arming_lock !== want.arming_lock)
                    report_mismatch("arming_lock", 32'(got.arming_lock),
                                    32'(want.arming_lock));
                if (got.event_total !== want.event_total)
                    report_mismatch("event_total", 32'(got.event_total),
                                    32'(want.event_total));
            end
        end
    end

    // Send one event transaction; valid stays high after acceptance until the next call.
    task automatic send_event(input logic [2:0] fn, input t_time now,
                              input logic [SUS_W-1:0] sus, input logic armed,
                              input logic thr_low, input logic sw);
        t_in_item ev;
        ev.func         = fn;
        ev.now_ms       = now;
        ev.suspend_us   = sus;
        ev.armed        = armed;
        ev.throttle_low = thr_low;
        ev.switch_on    = sw;
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            ev_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.data  <= ev;
        do @(posedge clk); while (!ev_ch.ready);
        predicted_status.push_back(failsafe_step(ev));
        sent_count++;
    endtask

    // Drop valid and hold until every pending result has come back.
    task automatic settle();
        ev_ch.valid <= 1'b0;
        do @(posedge clk); while (predicted_status.size() != 0);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] fd, input logic [CFG_W-1:0] lt,
                                  input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] tl,
                                  input logic [CFG_W-1:0] kill, input logic [CFG_W-1:0] drop,
                                  input logic [CFG_W-1:0] mon);
        logic [CFG_W-1:0] vals [NUM_REGS];
        vals = '{fd, lt, thr, tl, kill, drop, mon};
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= t_cfg_idx'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            case (t_cfg_idx'(i))
                CFG_FAIL_DELAY: cf_fail_delay = vals[i][7:0];
                CFG_LAND_TIME:  cf_land_time  = vals[i][7:0];
                CFG_LAND_THR:   cf_land_thr   = vals[i][10:0];
                CFG_THR_LOW:    cf_thr_low    = vals[i][8:0];
                CFG_KILL_MODE:  cf_kill       = vals[i][0];
                CFG_PROCEDURE:  cf_drop       = vals[i][0];
                CFG_MONITOR:    cf_monitor    = vals[i][0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Link hysteresis, suspend and resume with monitoring off, plus unused codes.
    task automatic test_link_events();
        send_event(FN_UPDATE, '0, '0, 1'b1, 1'b0, 1'b1);
        send_event(FN_UNUSED_LO, TIME_MAX, '1, 1'b1, 1'b1, 1'b1);
        send_event(FN_UNUSED_HI, '0, '0, 1'b0, 1'b0, 1'b0);
        send_event(FN_GOOD, 100, '0, 1'b0, 1'b0, 1'b0);
        send_event(FN_GOOD, 201, '0, 1'b0, 1'b0, 1'b0);
        send_event(FN_BAD, 1401, '0, 1'b0, 1'b0, 1'b0);
        send_event(FN_BAD, 1402, '0, 1'b0, 1'b0, 1'b0);
        send_event(FN_SUSPEND, 1403, '1, 1'b0, 1'b0, 1'b0);
        send_event(FN_RESUME, TIME_MAX, '0, 1'b0, 1'b0, 1'b0);
        send_event(FN_SUSPEND, '0, '0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_kill_switch();
        settle();
        apply_settings(10, 200, 1000, 100, 1, 0, 1);
        send_event(FN_RESUME, 5000, '0, 1'b1, 1'b1, 1'b0);
        send_event(FN_UPDATE, 5010, '0, 1'b1, 1'b1, 1'b1);
        send_event(FN_UPDATE, 5500, '0, 1'b1, 1'b1, 1'b1);
        send_event(FN_UPDATE, 6011, '0, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_auto_landing();
        settle();
        apply_settings(0, 0, 2000, 0, 0, 0, 1);
        send_event(FN_BAD, 20000, '0, 1'b1, 1'b0, 1'b0);
        send_event(FN_UPDATE, 20001, '0, 1'b1, 1'b0, 1'b0);
        send_event(FN_UPDATE, 20002, '0, 1'b1, 1'b0, 1'b0);
        send_event(FN_RESUME, 20010, '0, 1'b1, 1'b0, 1'b0);
        send_event(FN_UPDATE, 40000, '0, 1'b1, 1'b0, 1'b0);
        send_event(FN_UPDATE, 50003, '0, 1'b1, 1'b0, 1'b0);
    endtask

    // Just-disarm after a long low throttle, then the drop procedure.
    task automatic test_drop_and_disarm();
        settle();
        apply_settings(255, 255, 1000, 511, 0, 1, 1);
        send_event(FN_UPDATE, 100000, '0, 1'b0, 1'b1, 1'b0);
        send_event(FN_BAD, 100000, '0, 1'b0, 1'b1, 1'b0);
        send_event(FN_UPDATE, 100001, '0, 1'b1, 1'b1, 1'b0);
        send_event(FN_RESUME, 100002, '0, 1'b1, 1'b1, 1'b0);
        send_event(FN_UPDATE, 104000, '0, 1'b1, 1'b0, 1'b0);
        send_event(FN_BAD, 200000, '0, 1'b1, 1'b0, 1'b0);
        send_event(FN_UPDATE, 200001, '0, 1'b1, 1'b0, 1'b0);
    endtask

    // Plausible flight traffic: loss episodes, stick and arming changes, rare noise.
    task automatic run_flight_mix(input int n_items);
        t_time            t;
        logic             lost;
        logic             armed;
        logic             thr_low;
        logic             sw;
        int               roll;
        logic [2:0]       fn;
        logic [SUS_W-1:0] sus;
        if ($urandom_range(0, 3) == 0)
            t = TIME_MAX - t_time'($urandom_range(0, 300000));
        else
            t = $urandom;
        lost    = 1'b0;
        armed   = 1'b1;
        thr_low = 1'b0;
        sw      = 1'b0;
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 3)
                lost = !lost;
            if ($urandom_range(0, 99) < 2)
                armed = !armed;
            if ($urandom_range(0, 99) < 8)
                thr_low = !thr_low;
            if ($urandom_range(0, 99) < (sw ? 30 : 3))
                sw = !sw;
            roll = $urandom_range(0, 99);
            if (roll < 88)
                t = t + $urandom_range(0, lost ? 400 : 60);
            else if (roll < 98)
                t = t + $urandom_range(1000, 40000);
            else
                t = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 45)
                fn = FN_UPDATE;
            else if (roll < 77)
                fn = lost ? FN_BAD : FN_GOOD;
            else if (roll < 82)
                fn = lost ? FN_GOOD : FN_BAD;
            else if (roll < 88)
                fn = FN_SUSPEND;
            else if (roll < 91)
                fn = FN_RESUME;
            else if (roll < 98)
                fn = FN_UPDATE;
            else
                fn = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            sus = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2_000_000);
            send_event(fn, t, sus, armed, thr_low, sw);
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] fd;
        logic [CFG_W-1:0] lt;
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] tl;
        logic [CFG_W-1:0] kill;
        logic [CFG_W-1:0] drop;
        logic [CFG_W-1:0] mon;
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg)
                0: begin
                    fd = 10; lt = 200; thr = 1000; tl = 100; kill = 0; drop = 0; mon = 1;
                end
                1: begin
                    fd = 0; lt = 0; thr = 1000; tl = 0; kill = 0; drop = 0; mon = 1;
                end
                2: begin
                    fd = 255; lt = 255; thr = '1; tl = 511; kill = 1; drop = 1; mon = 1;
                end
                default: begin
                    // upper bits beyond each register's width are junk on purpose
                    fd   = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(0, 30))
                                                       : CFG_W'($urandom);
                    lt   = CFG_W'($urandom);
                    thr  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                       : CFG_W'($urandom_range(1000, 2000));
                    tl   = CFG_W'($urandom);
                    kill = CFG_W'($urandom);
                    drop = CFG_W'($urandom);
                    mon  = {(CFG_W-1)'($urandom), ($urandom_range(0, 99) < 85)};
                end
            endcase
            settle();
            apply_settings(fd, lt, thr, tl, kill, drop, mon);
            case (seg % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 53; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 53; end
                default: begin in_idle_pct = 37; out_stall_pct = 37; end
            endcase
            run_flight_mix(SEG_ITEMS);
        end
    endtask

    // Kill switch at the top of the time range: the rearm deadline wraps, so each update
    // chains two activations and hits the pass bound.
    task automatic test_wrap_chain();
        settle();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        apply_settings(10, 200, 1000, 100, 1, 0, 1);
        send_event(FN_RESUME, TIME_MAX, '0, 1'b1, 1'b1, 1'b1);
        repeat (WRAP_UPDATES)
            send_event(FN_UPDATE, TIME_MAX, $urandom, 1'b1, 1'b1, 1'b1);
    endtask

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                 predicted_status.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        ev_ch.valid = 1'b0;
        ev_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_link_events();
        test_kill_switch();
        test_auto_landing();
        test_drop_and_disarm();
        test_random_traffic();
        test_wrap_chain();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered link hysteresis, kill switch, landing, drop, disarm, rearm holds,");
        $display("%0d transactions sent, %0d results compared, event total at %0d, %0d errors",
                 sent_count, checked_count, fs_events, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
